### design/maf_pkg.sv
// Shared types and constants for the moving average filter.
package maf_pkg;

  // Default sizes
  localparam int MAX_LENGTH_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 24;

  // Width of the window length register
  localparam int CFG_WIDTH = 7;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_DIVIDE,
    ST_FINISH
  } maf_state_t;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### design/maf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module maf_ram #(
  parameter int WIDTH = maf_pkg::SAMPLE_WIDTH_DEF,
  parameter int DEPTH = maf_pkg::MAX_LENGTH_DEF,
  parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_WIDTH-1:0] waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic [ADDR_WIDTH-1:0] raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/maf_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module maf_divider #(
  parameter int DIVIDEND_WIDTH = 30,
  parameter int DIVISOR_WIDTH  = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DIVIDEND_WIDTH-1:0] dividend,
  input  logic [DIVISOR_WIDTH-1:0]  divisor,
  output logic [DIVIDEND_WIDTH-1:0] quotient,
  output maf_pkg::div_stat_t        stat
);

  import maf_pkg::*;

  localparam int CNT_WIDTH = $clog2(DIVIDEND_WIDTH + 1);

  logic                     busy;
  logic                     done;
  logic [CNT_WIDTH-1:0]     count;
  logic [DIVISOR_WIDTH-1:0] rem;
  logic [DIVISOR_WIDTH-1:0] dvs;
  logic [DIVISOR_WIDTH:0]   rem_shift;
  logic [DIVISOR_WIDTH:0]   diff;
  logic                     fits;

  // Trial subtraction of the divisor from the shifted remainder
  always_comb begin
    rem_shift = {rem, quotient[DIVIDEND_WIDTH-1]};
    diff      = rem_shift - {1'b0, dvs};
    fits      = (rem_shift >= {1'b0, dvs});
  end

  // Control: count down one step per quotient bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_WIDTH'(DIVIDEND_WIDTH);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out at the top, quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? diff[DIVISOR_WIDTH-1:0] : rem_shift[DIVISOR_WIDTH-1:0];
      quotient <= {quotient[DIVIDEND_WIDTH-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### design/moving_average_filter.sv
// Top level of the moving average filter: sequencer, ring RAM and divider.
//
// Each input word is a signed sample; the block answers with one word, the
// mean of the samples held in the window, truncated toward zero. While the
// window is filling it divides by the number of samples received, once full
// by the window length. A running sum is kept: the new sample is added and
// the overwritten ring entry subtracted. The mean comes from a one-bit-per-
// cycle divider over the sum width (SAMPLE_WIDTH + log2(MAX_LENGTH), 30 bits
// by default). The input stays not ready from acceptance of a sample until
// its result is loaded into the output register, so a new sample is not
// taken while the last is in work. With a window length of zero a sample is
// passed through unchanged and no window state changes. Lengths above
// MAX_LENGTH act as MAX_LENGTH. Writing the window length clears the window
// (count, index and sum); write it only while the block is idle. The result
// waits in an output register until taken.
module moving_average_filter #(
  parameter int MAX_LENGTH   = maf_pkg::MAX_LENGTH_DEF,
  parameter int SAMPLE_WIDTH = maf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration: window_length
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [maf_pkg::CFG_WIDTH-1:0]        cfg_data,
  // Input words
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // sample_in
  // Output words
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata   // average_out
);

  import maf_pkg::*;

  localparam int TDATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int IDX_WIDTH   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int LEN_WIDTH   = $clog2(MAX_LENGTH + 1);
  localparam int CMP_WIDTH   = (LEN_WIDTH > CFG_WIDTH) ? LEN_WIDTH : CFG_WIDTH;
  localparam int SUM_WIDTH   = SAMPLE_WIDTH + $clog2(MAX_LENGTH);

  maf_state_t state, state_next;

  logic [CFG_WIDTH-1:0]           window_length;
  logic [LEN_WIDTH-1:0]           len_eff;
  logic [IDX_WIDTH-1:0]           write_index;
  logic [LEN_WIDTH-1:0]           fill_count;
  logic signed [SUM_WIDTH-1:0]    running_sum;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic [SAMPLE_WIDTH-1:0]        result;
  logic                           sum_neg;
  logic [SAMPLE_WIDTH-1:0]        out_data;
  logic                           out_valid;

  logic [SAMPLE_WIDTH-1:0]        ram_rdata;
  logic                           ram_we;
  logic signed [SAMPLE_WIDTH-1:0] old_sample;
  logic [LEN_WIDTH-1:0]           slot_inc;
  logic [SUM_WIDTH-1:0]           sum_mag;
  logic [SUM_WIDTH-1:0]           quotient;
  logic [SUM_WIDTH-1:0]           quot_signed;
  logic                           div_start;
  div_stat_t                      div_stat;
  logic                           accept;
  logic                           out_load;

  // Effective window: register saturated at MAX_LENGTH
  always_comb begin
    if (CMP_WIDTH'(window_length) > CMP_WIDTH'(MAX_LENGTH)) begin
      len_eff = LEN_WIDTH'(MAX_LENGTH);
    end else begin
      len_eff = LEN_WIDTH'(window_length);
    end
  end

  // Overwritten entry only counts once the window is full
  assign old_sample = (fill_count == len_eff) ? $signed(ram_rdata) : '0;
  assign slot_inc   = LEN_WIDTH'(write_index) + 1'b1;

  // Divider operands and signed quotient
  assign sum_mag     = running_sum[SUM_WIDTH-1] ? SUM_WIDTH'(-running_sum)
                                                : SUM_WIDTH'(running_sum);
  assign quot_signed = sum_neg ? (~quotient + 1'b1) : quotient;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  // Sequencer: next state and control strobes
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = (len_eff == '0) ? ST_FINISH : ST_READ;
        end
      end
      ST_READ: begin
        ram_we     = 1'b1;
        state_next = ST_START;
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window control: length register, fill count, index and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= '0;
      write_index   <= '0;
      fill_count    <= '0;
      running_sum   <= '0;
    end else if (cfg_valid) begin
      window_length <= cfg_data;
      write_index   <= '0;
      fill_count    <= '0;
      running_sum   <= '0;
    end else if (ram_we) begin
      running_sum <= running_sum - SUM_WIDTH'(old_sample) + SUM_WIDTH'(sample);
      write_index <= (slot_inc >= len_eff) ? '0 : IDX_WIDTH'(slot_inc);
      if (fill_count < len_eff) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // Sample, sign and result holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= $signed(s_axis_tdata[SAMPLE_WIDTH-1:0]);
      result <= s_axis_tdata[SAMPLE_WIDTH-1:0];
    end else if (div_start) begin
      sum_neg <= running_sum[SUM_WIDTH-1];
    end else if (div_stat.done) begin
      result <= quot_signed[SAMPLE_WIDTH-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_WIDTH'(out_data);

  // Sample ring
  maf_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_LENGTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_index),
    .wdata (sample),
    .raddr (write_index),
    .rdata (ram_rdata)
  );

  // Mean divider
  maf_divider #(
    .DIVIDEND_WIDTH (SUM_WIDTH),
    .DIVISOR_WIDTH  (LEN_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (fill_count),
    .quotient (quotient),
    .stat     (div_stat)
  );

endmodule
